// ===== hdl/sfd_pkg.sv =====
// Shared types and constants for the sync-framed deframer with Fletcher-16 check.
// No dependencies.
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam logic [ByteW-1:0] SumInit = 8'hff;
  localparam logic [ByteW-1:0] SyncReset = 8'haa;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd = 1'b1;

  // frame parser phases, one-hot
  typedef enum logic [6:0] {
    PH_SYNC1 = 7'b0000001,
    PH_SYNC2 = 7'b0000010,
    PH_TYPE  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_SUM2  = 7'b0100000,
    PH_SUM1  = 7'b1000000
  } phase_e;

  // one result record
  typedef struct packed {
    logic             checksum_ok;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_type;
    logic [ByteW-1:0] data_byte;
    logic             kind;
    logic             last;
  } rec_t;

  // checksum unit control
  typedef struct packed {
    logic en;       // fold this byte in
    logic restart;  // start from SumInit before folding
  } sum_ctl_t;

endpackage

// ===== hdl/sfd_fletch.sv =====
// Fletcher-16 running sums with end-around-carry folding into 1..255.
// Depends on sfd_pkg.
module sfd_fletch import sfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sum_ctl_t         ctl_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [ByteW-1:0] sum1_o,
  output logic [ByteW-1:0] sum2_o
);

  logic [ByteW-1:0] sum1_q, sum1_d, sum2_q, sum2_d;
  logic [ByteW-1:0] base1, base2;
  logic [ByteW:0]   raw1, raw2;

  always_comb begin
    base1  = ctl_i.restart ? SumInit : sum1_q;
    base2  = ctl_i.restart ? SumInit : sum2_q;
    raw1   = {1'b0, base1} + {1'b0, byte_i};
    sum1_d = raw1[ByteW-1:0] + {{(ByteW-1){1'b0}}, raw1[ByteW]};
    raw2   = {1'b0, base2} + {1'b0, sum1_d};
    sum2_d = raw2[ByteW-1:0] + {{(ByteW-1){1'b0}}, raw2[ByteW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum1_q <= SumInit;
      sum2_q <= SumInit;
    end else if (ctl_i.en) begin
      sum1_q <= sum1_d;
      sum2_q <= sum2_d;
    end
  end

  assign sum1_o = sum1_q;
  assign sum2_o = sum2_q;

endmodule

// ===== hdl/sfd_parse.sv =====
// Frame parser: sync hunt, header capture, payload indexing, checksum compare.
// Depends on sfd_pkg and sfd_fletch.
module sfd_parse import sfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic [ByteW-1:0] sync_byte_i,
  output logic             res_valid_o,
  output rec_t             rec_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] type_q, type_d, len_q, len_d, cnt_q, cnt_d, rsum2_q, rsum2_d;
  logic [ByteW-1:0] cnt_inc, sum1, sum2;
  sum_ctl_t         sum_ctl;

  sfd_fletch u_fletch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sum_ctl),
    .byte_i (byte_i),
    .sum1_o (sum1),
    .sum2_o (sum2)
  );

  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    rsum2_d     = rsum2_q;
    sum_ctl     = '0;
    res_valid_o = 1'b0;
    rec_o       = '0;
    rec_o.frame_type   = type_q;
    rec_o.frame_length = len_q;
    unique case (phase_q)
      PH_SYNC2: begin
        phase_d = (byte_i == sync_byte_i) ? PH_TYPE : PH_SYNC1;
      end
      PH_TYPE: begin
        type_d          = byte_i;
        sum_ctl.en      = step_i;
        sum_ctl.restart = 1'b1;
        phase_d         = PH_LEN;
      end
      PH_LEN: begin
        len_d      = byte_i;
        cnt_d      = '0;
        sum_ctl.en = step_i;
        phase_d    = (byte_i == '0) ? PH_SUM2 : PH_DATA;
      end
      PH_DATA: begin
        sum_ctl.en       = step_i;
        res_valid_o      = step_i;
        rec_o.kind       = KindPayload;
        rec_o.data_byte  = byte_i;
        rec_o.byte_index = cnt_q;
        if (cnt_inc == len_q) begin
          phase_d = PH_SUM2;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_SUM2: begin
        rsum2_d = byte_i;
        phase_d = PH_SUM1;
      end
      PH_SUM1: begin
        res_valid_o       = step_i;
        rec_o.kind        = KindEnd;
        rec_o.last        = 1'b1;
        rec_o.checksum_ok = (rsum2_q == sum2) && (byte_i == sum1);
        phase_d           = PH_SYNC1;
      end
      default: begin  // first sync and any unused code
        phase_d = (byte_i == sync_byte_i) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      type_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      rsum2_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      rsum2_q <= rsum2_d;
    end
  end

endmodule

// ===== hdl/sync_frame_deframer_fletcher16.sv =====
// Sync-framed byte stream deframer with Fletcher-16 check (top level).
// Path from input request to result request: input register, then result register.
// Throughput: one byte per cycle while the result slot can take it; the parser,
// both folded adds and the sum compare are combinational between the two registers.
// Reset (async, active low): hunt for first sync, sums 0xff, sync byte 0xaa.
// Depends on sfd_pkg, sfd_parse, sfd_fletch.
module sync_frame_deframer_fletcher16 import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: sync byte value
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // frame records
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [15:8] frame_type,
                                      // [23:16] byte_index, [31:24] frame_length,
                                      // [32] checksum_ok, [39:33] zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast
);

  logic [ByteW-1:0] sync_q;
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_vld_q;
  rec_t             out_rec_q;
  logic             out_free, step, res_valid;
  rec_t             rec;

  // The result slot frees when empty or drained this cycle; the held byte
  // moves through the parser whenever the slot can take its result.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SyncReset;
    end else if (cfg_we_i) begin
      sync_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  sfd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .sync_byte_i (sync_q),
    .res_valid_o (res_valid),
    .rec_o       (rec)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_rec_q <= rec;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_rec_q.checksum_ok, out_rec_q.frame_length,
                          out_rec_q.byte_index, out_rec_q.frame_type,
                          out_rec_q.data_byte};
  assign m_axis_tuser  = out_rec_q.kind;
  assign m_axis_tlast  = out_rec_q.last;

endmodule

// ===== tb/tb_sync_frame_deframer_fletcher16.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the sync-framed byte deframer with Fletcher-16 check.
// Streams framed and broken byte sequences with random gaps and stalls; records
// are predicted in-bench. Depends on sfd_pkg and sync_frame_deframer_fletcher16.
module tb_sync_frame_deframer_fletcher16;
  import sfd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainPad   = 6;     // input and result registers plus margin
  localparam int unsigned FullFrame  = 1000;  // cut value that sends the whole frame

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // bench copy of the parser state and the sync register
  phase_e     ph;
  logic [7:0] sync_val;
  logic [7:0] held_type;
  logic [7:0] held_len;
  logic [7:0] pay_cnt;
  logic [7:0] sum1;
  logic [7:0] sum2;
  logic [7:0] rx_sum2;

  // records owed by the block, oldest first
  rec_t frame_recs_due[$];

  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_left     = 0;   // forced receiver hold-off, in cycles
  int unsigned items_sent    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned err_cnt       = 0;

  sync_frame_deframer_fletcher16 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost record ends here
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d records still owed", $time, frame_recs_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // end-around carry add, keeps sums in 1..255
  function automatic logic [7:0] fold8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  task automatic absorb(input logic [7:0] b);
    sum1 = fold8(sum1, b);
    sum2 = fold8(sum2, sum1);
  endtask

  task automatic reset_model();
    sync_val  = SyncReset;
    ph        = PH_SYNC1;
    held_type = '0;
    held_len  = '0;
    pay_cnt   = '0;
    sum1      = SumInit;
    sum2      = SumInit;
    rx_sum2   = '0;
  endtask

  // advance the parser copy by one accepted byte; queue the record it yields
  task automatic deframe_byte(input logic [7:0] b);
    rec_t r;
    r = '0;
    r.kind = KindPayload;
    case (ph)
      PH_SYNC2: begin
        // a mismatch here is consumed, not retried as a first sync
        ph = (b == sync_val) ? PH_TYPE : PH_SYNC1;
      end
      PH_TYPE: begin
        held_type = b;
        sum1 = SumInit;
        sum2 = SumInit;
        absorb(b);
        ph = PH_LEN;
      end
      PH_LEN: begin
        held_len = b;
        pay_cnt  = '0;
        absorb(b);
        ph = (b == 8'd0) ? PH_SUM2 : PH_DATA;
      end
      PH_DATA: begin
        absorb(b);
        r.data_byte    = b;
        r.frame_type   = held_type;
        r.byte_index   = pay_cnt;
        r.frame_length = held_len;
        frame_recs_due.push_back(r);
        if (pay_cnt + 8'd1 == held_len) begin
          ph = PH_SUM2;
        end else begin
          pay_cnt = pay_cnt + 8'd1;
        end
      end
      PH_SUM2: begin
        rx_sum2 = b;
        ph = PH_SUM1;
      end
      PH_SUM1: begin
        r.kind         = KindEnd;
        r.frame_type   = held_type;
        r.frame_length = held_len;
        r.checksum_ok  = (rx_sum2 == sum2) && (b == sum1);
        r.last         = 1'b1;
        frame_recs_due.push_back(r);
        ph = PH_SYNC1;
      end
      default: begin
        ph = (b == sync_val) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, forced hold-off, compare against oldest record
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_record();
    rec_t e;
    if (frame_recs_due.size() == 0) begin
      $display("%0t: unexpected record, expected none, got tdata=%h tuser=%b tlast=%b",
               $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      err_cnt++;
      return;
    end
    e = frame_recs_due.pop_front();
    check_field("kind",         {7'd0, e.kind},        {7'd0, m_axis_tuser});
    check_field("data_byte",    e.data_byte,           m_axis_tdata[7:0]);
    check_field("frame_type",   e.frame_type,          m_axis_tdata[15:8]);
    check_field("byte_index",   e.byte_index,          m_axis_tdata[23:16]);
    check_field("frame_length", e.frame_length,        m_axis_tdata[31:24]);
    check_field("checksum_ok",  {7'd0, e.checksum_ok}, {7'd0, m_axis_tdata[32]});
    check_field("last",         {7'd0, e.last},        {7'd0, m_axis_tlast});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_record();
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one byte and return at the edge that takes it. tvalid stays high on
  // return so back-to-back requests need no second assignment in one step.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    deframe_byte(b);
    items_sent++;
  endtask

  task automatic stop_src();
    s_axis_tvalid <= 1'b0;
  endtask

  // pipe empty: nothing owed and no byte left in flight
  task automatic wait_idle();
    while (frame_recs_due.size() != 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic apply_sync(input logic [7:0] v);
    stop_src();
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sync_val = v;
  endtask

  // feed non-sync filler until the parser is back to hunting
  task automatic to_hunt();
    logic [7:0] b;
    while (ph != PH_SYNC1) begin
      do b = 8'($urandom_range(0, 255)); while (b == sync_val);
      send_byte(b);
    end
  endtask

  // body = type, length, payload; sync pair and both sums are added here
  task automatic send_frame(input byte_q_t body, input bit corrupt,
                            input int unsigned cut);
    byte_q_t    wire_q;
    logic [7:0] s1;
    logic [7:0] s2;
    s1 = SumInit;
    s2 = SumInit;
    foreach (body[i]) begin
      s1 = fold8(s1, body[i]);
      s2 = fold8(s2, s1);
    end
    if (corrupt) begin
      case ($urandom_range(0, 2))
        0:       s2 ^= 8'($urandom_range(1, 255));
        1:       s1 ^= 8'($urandom_range(1, 255));
        default: begin
          s2 ^= 8'($urandom_range(1, 255));
          s1 ^= 8'($urandom_range(1, 255));
        end
      endcase
    end
    wire_q.push_back(sync_val);
    wire_q.push_back(sync_val);
    foreach (body[i]) wire_q.push_back(body[i]);
    wire_q.push_back(s2);
    wire_q.push_back(s1);
    for (int i = 0; i < wire_q.size() && i < cut; i++) send_byte(wire_q[i]);
  endtask

  // payload leans on the sync value so in-frame sync bytes show up often
  function automatic byte_q_t rand_body(input int unsigned len);
    byte_q_t body;
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(8'(len));
    repeat (len) begin
      body.push_back(($urandom_range(0, 7) == 0) ? sync_val : 8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  function automatic int unsigned rand_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
  endfunction

  // short burst of junk, sync values included
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_byte(($urandom_range(0, 3) == 0) ? sync_val : 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // zero length, all-zero header: sum2 follows the length byte
    send_frame('{8'h00, 8'h00}, 1'b0, FullFrame);
    // single payload byte, all-ones type and data
    send_frame('{8'hff, 8'h01, 8'hff}, 1'b0, FullFrame);
    // second sync mismatch drops back to hunting
    send_byte(sync_val);
    send_byte(~sync_val);
    // sync values as type and payload must not resync; bad check on top
    send_frame('{sync_val, 8'h03, sync_val, sync_val, 8'h00}, 1'b1, FullFrame);
  endtask

  // sync register at both extremes and one random value
  task automatic test_sync_values();
    logic [7:0] vals[3];
    vals = '{8'h00, 8'hff, 8'($urandom_range(1, 254))};
    foreach (vals[k]) begin
      apply_sync(vals[k]);
      to_hunt();
      repeat (3) send_frame(rand_body(rand_len()), ($urandom_range(0, 3) == 0), FullFrame);
      send_noise();
      to_hunt();
      send_frame(rand_body(rand_len()), 1'b0, FullFrame);
    end
  endtask

  // mostly clean frames; some corrupted, truncated or buried in junk
  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned budget, input bit with_long);
    int unsigned stop_at;
    int unsigned pick;
    apply_sync(8'($urandom_range(0, 255)));
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at = items_sent + budget;
    to_hunt();
    if (with_long) begin
      // longest payload reaches the top byte index
      send_frame(rand_body(255), 1'b0, FullFrame);
    end
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_noise();
      end else if (pick < 16) begin
        send_frame(rand_body(rand_len()), 1'b0, $urandom_range(2, 8));
      end else begin
        send_frame(rand_body(rand_len()), ($urandom_range(0, 5) == 0), FullFrame);
      end
      to_hunt();
    end
  endtask

  // receiver holds off while requests keep coming, so the input side stalls
  task automatic test_backpressure();
    stop_src();
    wait_idle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_left     = 400;
    to_hunt();
    repeat (4) send_frame(rand_body(20), 1'b0, FullFrame);
  endtask

  initial begin
    reset_model();
    src_idle_pct  = 11;
    sink_idle_pct = 51;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_sync_values();
    test_random_traffic(11, 51, 350, 1'b1);
    test_random_traffic(51, 11, 350, 1'b0);
    test_random_traffic(0, 0, 350, 1'b0);
    test_backpressure();

    stop_src();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sfd_pkg.sv
hdl/sfd_fletch.sv
hdl/sfd_parse.sv
hdl/sync_frame_deframer_fletcher16.sv
tb/tb_sync_frame_deframer_fletcher16.sv
